/* rtl/slru_pkg.sv */
`default_nettype none
// ============================================================================
// slru_pkg
// Shared types and constants for the two-segment key/value cache.
// ============================================================================
package slru_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int USES_W  = 2;
    localparam int LIMIT_W = 4;

    localparam logic [USES_W-1:0] USES_NEW     = 2'd1;
    localparam logic [USES_W-1:0] USES_PROMOTE = 2'd2;
    localparam logic [USES_W-1:0] USES_MAX     = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic REG_PROBATION_LIMIT = 1'b0;
    localparam logic REG_PROTECTED_LIMIT = 1'b1;

    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
        logic [USES_W-1:0]         uses;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic write;
        logic set_use2;
        logic bump_use;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/slru_cell.sv */
`default_nettype none
// ============================================================================
// slru_cell
// One cache slot: holds an entry, compares it against the probe key and
// takes its neighbour's entry, a new entry or an in-place update.
// ============================================================================
module slru_cell
    import slru_pkg::*;
(
    input  wire logic                      clk,
    input  wire cell_ctrl_t                ctrl,
    input  wire logic                      valid,
    input  wire logic signed [KEY_W-1:0]   probe_key,
    input  wire logic signed [VALUE_W-1:0] write_value,
    input  wire entry_t                    neighbour,
    input  wire entry_t                    load_entry,
    output entry_t                         entry,
    output logic                           match
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = load_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbour;
        end
        else
        begin
            if (ctrl.write)
            begin
                entry_next.value = write_value;
            end
            if (ctrl.set_use2)
            begin
                entry_next.uses = USES_PROMOTE;
            end
            else if (ctrl.bump_use && (entry_reg.uses != USES_MAX))
            begin
                entry_next.uses = entry_reg.uses + USES_NEW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = valid && (entry_reg.key == probe_key);

endmodule
`default_nettype wire

/* rtl/segmented_lru_cache.sv */
`default_nettype none
// ============================================================================
// segmented_lru_cache
// Two-segment key/value cache built from two rows of shifting cells.
// ============================================================================
// A get's result appears in the cycle after acceptance; a put gives none.
// One transaction is accepted per cycle unless an unread result blocks it:
// every cell compares the key in parallel and the rows shift or load in
// the same cycle. Reset empties both segments and sets both limits to
// eight; no clearing pass is needed, so the block is ready once reset ends.
module segmented_lru_cache
    import slru_pkg::*;
#(
    parameter int PROBATION_DEPTH = 8,
    parameter int PROTECTED_DEPTH = 8
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      opcode,
    input  wire logic signed [KEY_W-1:0]   key,
    input  wire logic signed [VALUE_W-1:0] write_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           hit,
    output logic signed [VALUE_W-1:0]      read_value
);

    localparam int PFW = $clog2(PROBATION_DEPTH + 1);
    localparam int QFW = $clog2(PROTECTED_DEPTH + 1);
    localparam int PLW = ((PFW > LIMIT_W) ? PFW : LIMIT_W) + 1;
    localparam int QLW = ((QFW > LIMIT_W) ? QFW : LIMIT_W) + 1;

    logic [LIMIT_W-1:0] p_limit_reg;
    logic [LIMIT_W-1:0] q_limit_reg;
    logic [PFW-1:0]     p_fill_reg;
    logic [PFW-1:0]     p_fill_next;
    logic [QFW-1:0]     q_fill_reg;
    logic [QFW-1:0]     q_fill_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic signed [VALUE_W-1:0] read_value_next;

    entry_t                     p_cells [PROBATION_DEPTH];
    entry_t                     q_cells [PROTECTED_DEPTH];
    logic [PROBATION_DEPTH-1:0] p_match;
    logic [PROTECTED_DEPTH-1:0] q_match;

    logic           accept;
    logic           is_put;
    logic           p_hit;
    logic           q_hit;
    logic           insert;
    logic           p_drop;
    logic           promote;
    logic           q_drop;
    logic [PLW-1:0] p_lim;
    logic [QLW-1:0] q_lim;
    logic [PFW-1:0] p_pos;
    logic [QFW-1:0] q_pos;
    logic [PFW-1:0] p_last;
    logic [QFW-1:0] q_last;
    entry_t         promote_entry;
    logic           cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_limit_reg <= LIMIT_RESET;
            q_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_PROBATION_LIMIT: p_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_PROTECTED_LIMIT: q_limit_reg <= pwdata[LIMIT_W-1:0];
                default:             p_limit_reg <= p_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_PROBATION_LIMIT: prdata[LIMIT_W-1:0] = p_limit_reg;
            REG_PROTECTED_LIMIT: prdata[LIMIT_W-1:0] = q_limit_reg;
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        p_lim = PLW'(p_limit_reg);
        if (p_lim == '0)
        begin
            p_lim = PLW'(1);
        end
        else if (p_lim > PLW'(PROBATION_DEPTH))
        begin
            p_lim = PLW'(PROBATION_DEPTH);
        end
        q_lim = QLW'(q_limit_reg);
        if (q_lim > QLW'(PROTECTED_DEPTH))
        begin
            q_lim = QLW'(PROTECTED_DEPTH);
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_put   = (opcode == OP_PUT);
    assign p_hit    = |p_match;
    assign q_hit    = |q_match;
    assign insert   = accept && is_put && !p_hit && !q_hit;
    assign p_drop   = insert && (PLW'(p_fill_reg) >= p_lim);
    assign promote  = p_drop && (p_cells[0].uses >= USES_PROMOTE);
    assign q_drop   = promote && ((QLW'(q_fill_reg) + QLW'(1)) > q_lim);
    assign p_last   = p_fill_reg - PFW'(1);
    assign q_last   = q_fill_reg - QFW'(1);
    assign p_pos    = p_drop ? p_last : p_fill_reg;
    assign q_pos    = q_drop ? q_last : q_fill_reg;

    always_comb
    begin
        promote_entry       = p_cells[0];
        promote_entry.uses  = '0;
    end

    always_comb
    begin
        p_fill_next = p_fill_reg;
        q_fill_next = q_fill_reg;
        if (insert && !p_drop)
        begin
            p_fill_next = p_fill_reg + PFW'(1);
        end
        if (promote && !q_drop)
        begin
            q_fill_next = q_fill_reg + QFW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_fill_reg <= '0;
            q_fill_reg <= '0;
        end
        else
        begin
            p_fill_reg <= p_fill_next;
            q_fill_reg <= q_fill_next;
        end
    end

    for (genvar i = 0; i < PROBATION_DEPTH; i++)
    begin : g_prob
        localparam logic [PFW-1:0] IDX = PFW'(i);
        localparam int             NB  = (i + 1 < PROBATION_DEPTH) ? i + 1 : i;
        cell_ctrl_t ctrl;
        entry_t     load_entry;

        always_comb
        begin
            ctrl.shift    = p_drop && (IDX < p_last);
            ctrl.load     = insert && (p_pos == IDX);
            ctrl.write    = accept && is_put && p_match[i];
            ctrl.set_use2 = accept && is_put && p_match[i];
            ctrl.bump_use = accept && !is_put && p_match[i];
            load_entry.key   = key;
            load_entry.value = write_value;
            load_entry.uses  = USES_NEW;
        end

        slru_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (IDX < p_fill_reg),
            .probe_key   (key),
            .write_value (write_value),
            .neighbour   (p_cells[NB]),
            .load_entry  (load_entry),
            .entry       (p_cells[i]),
            .match       (p_match[i])
        );
    end

    for (genvar i = 0; i < PROTECTED_DEPTH; i++)
    begin : g_prot
        localparam logic [QFW-1:0] IDX = QFW'(i);
        localparam int             NB  = (i + 1 < PROTECTED_DEPTH) ? i + 1 : i;
        cell_ctrl_t ctrl;

        always_comb
        begin
            ctrl.shift    = q_drop && (IDX < q_last);
            ctrl.load     = promote && (q_pos == IDX);
            ctrl.write    = accept && is_put && q_match[i];
            ctrl.set_use2 = 1'b0;
            ctrl.bump_use = 1'b0;
        end

        slru_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (IDX < q_fill_reg),
            .probe_key   (key),
            .write_value (write_value),
            .neighbour   (q_cells[NB]),
            .load_entry  (promote_entry),
            .entry       (q_cells[i]),
            .match       (q_match[i])
        );
    end

    always_comb
    begin
        logic signed [VALUE_W-1:0] p_val;
        logic signed [VALUE_W-1:0] q_val;
        p_val = '0;
        q_val = '0;
        for (int i = 0; i < PROBATION_DEPTH; i++)
        begin
            p_val = p_val | (p_cells[i].value & {VALUE_W{p_match[i]}});
        end
        for (int i = 0; i < PROTECTED_DEPTH; i++)
        begin
            q_val = q_val | (q_cells[i].value & {VALUE_W{q_match[i]}});
        end

        out_valid_next  = out_valid_reg;
        hit_next        = hit_reg;
        read_value_next = read_value_reg;
        if (accept && !is_put)
        begin
            out_valid_next  = 1'b1;
            hit_next        = p_hit || q_hit;
            read_value_next = p_hit ? p_val : q_val;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        read_value_reg <= read_value_next;
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

`ifndef NO_ASSERTIONS
    a_prob_fill: assert property (@(posedge clk) disable iff (!rst_n)
        PFW'(PROBATION_DEPTH) >= p_fill_reg)
        else $error("Probation fill exceeds its depth.");

    a_prot_fill: assert property (@(posedge clk) disable iff (!rst_n)
        QFW'(PROTECTED_DEPTH) >= q_fill_reg)
        else $error("Protected fill exceeds its depth.");

    a_unique_prob: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(p_match))
        else $error("Key matches more than one probation entry.");

    a_unique_seg: assert property (@(posedge clk) disable iff (!rst_n)
        !(p_hit && q_hit))
        else $error("Key is held in both segments.");

    a_put_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_put && !out_valid_reg) |=> !out_valid)
        else $error("A put transaction produced a result.");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for the two-segment key/value cache.
// A scoreboard class keeps its own copy of both segments and both limits,
// predicts the answer to every accepted get and compares it with each
// result that leaves the block. Plain tasks drive a directed opening,
// then phases of random gets and puts over small key pools under several
// limit settings, with random idling on both channels and one long
// receiver hold-off that makes the block stall its input.
// ============================================================================
module tb;
    import slru_pkg::*;

    localparam int PROB_CELLS    = 8;
    localparam int PROT_CELLS    = 8;
    localparam int ITEMS_PER_RUN = 150;
    localparam int IDLE_LIMIT    = 4000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic             hit;
        logic [VALUE_W-1:0] value;
    } lookup_t;

    class lookup_scoreboard;
        logic [KEY_W-1:0]   prob_key [PROB_CELLS];
        logic [VALUE_W-1:0] prob_val [PROB_CELLS];
        logic [USES_W-1:0]  prob_uses[PROB_CELLS];
        int                 prob_fill;
        logic [KEY_W-1:0]   prot_key [PROT_CELLS];
        logic [VALUE_W-1:0] prot_val [PROT_CELLS];
        int                 prot_fill;
        logic [LIMIT_W-1:0] prob_limit_reg;
        logic [LIMIT_W-1:0] prot_limit_reg;
        lookup_t            awaited[$];
        int                 errors;

        function new();
            prob_fill      = 0;
            prot_fill      = 0;
            prob_limit_reg = LIMIT_RESET;
            prot_limit_reg = LIMIT_RESET;
            errors         = 0;
        endfunction

        function void set_limit(logic idx, logic [LIMIT_W-1:0] val);
            if (idx == REG_PROBATION_LIMIT)
                prob_limit_reg = val;
            else
                prot_limit_reg = val;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void drop_prot_oldest();
            if (prot_fill == 0)
                return;
            for (int i = 1; i < prot_fill; i++)
            begin
                prot_key[i-1] = prot_key[i];
                prot_val[i-1] = prot_val[i];
            end
            prot_fill--;
        endfunction

        function void promote(logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
            int lim;
            lim = (prot_limit_reg > PROT_CELLS) ? PROT_CELLS : int'(prot_limit_reg);
            if (prot_fill >= PROT_CELLS)
            begin
                drop_prot_oldest();
                prot_key[prot_fill] = k;
                prot_val[prot_fill] = v;
                prot_fill++;
            end
            else
            begin
                prot_key[prot_fill] = k;
                prot_val[prot_fill] = v;
                prot_fill++;
                if (prot_fill > lim)
                    drop_prot_oldest();
            end
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
            int      p;
            int      q;
            int      lim;
            lookup_t res;
            logic [KEY_W-1:0]   old_key;
            logic [VALUE_W-1:0] old_val;
            logic               moves;
            p = -1;
            q = -1;
            for (int i = 0; i < prob_fill; i++)
                if (p < 0 && prob_key[i] == k)
                    p = i;
            for (int i = 0; i < prot_fill; i++)
                if (q < 0 && prot_key[i] == k)
                    q = i;
            if (op == OP_GET)
            begin
                if (p >= 0)
                begin
                    if (prob_uses[p] != USES_MAX)
                        prob_uses[p] = prob_uses[p] + 1'b1;
                    res.hit   = 1'b1;
                    res.value = prob_val[p];
                end
                else if (q >= 0)
                begin
                    res.hit   = 1'b1;
                    res.value = prot_val[q];
                end
                else
                begin
                    res.hit   = 1'b0;
                    res.value = '0;
                end
                awaited.push_back(res);
                return;
            end
            if (p >= 0)
            begin
                prob_val[p]  = v;
                prob_uses[p] = USES_PROMOTE;
                return;
            end
            if (q >= 0)
            begin
                prot_val[q] = v;
                return;
            end
            lim = (prob_limit_reg < 1) ? 1 :
                  (prob_limit_reg > PROB_CELLS) ? PROB_CELLS : int'(prob_limit_reg);
            if (prob_fill >= lim && prob_fill > 0)
            begin
                old_key = prob_key[0];
                old_val = prob_val[0];
                moves   = (prob_uses[0] >= USES_PROMOTE);
                for (int i = 1; i < prob_fill; i++)
                begin
                    prob_key[i-1]  = prob_key[i];
                    prob_val[i-1]  = prob_val[i];
                    prob_uses[i-1] = prob_uses[i];
                end
                prob_fill--;
                if (moves)
                    promote(old_key, old_val);
            end
            if (prob_fill < PROB_CELLS)
            begin
                prob_key[prob_fill]  = k;
                prob_val[prob_fill]  = v;
                prob_uses[prob_fill] = USES_NEW;
                prob_fill++;
            end
        endfunction

        function void check_lookup(logic got_hit, logic [VALUE_W-1:0] got_value);
            lookup_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: hit=%0b read_value=%h", got_hit, got_value);
                return;
            end
            want = awaited.pop_front();
            if (got_hit !== want.hit || got_value !== want.value)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected hit=%0b read_value=%h, got hit=%0b read_value=%h",
                             want.hit, want.value, got_hit, got_value);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic opcode;
    logic signed [KEY_W-1:0] key;
    logic signed [VALUE_W-1:0] write_value;
    logic out_valid;
    logic out_ready;
    logic hit;
    logic signed [VALUE_W-1:0] read_value;

    lookup_scoreboard sb;
    bit steady;
    bit hold_request;
    logic [KEY_W-1:0] key_pool[];

    segmented_lru_cache #(
        .PROBATION_DEPTH(PROB_CELLS),
        .PROTECTED_DEPTH(PROT_CELLS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .key(key),
        .write_value(write_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit(hit),
        .read_value(read_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Each accepted transaction is noted before any result of the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready)
                sb.note_request(opcode, key, write_value);
            if (out_valid && out_ready)
                sb.check_lookup(hit, read_value);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = 400;
            end
            if (steady)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end
        end
    end

    task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                             input logic [VALUE_W-1:0] v);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        opcode      <= op;
        key         <= k;
        write_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic end_stream();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic idx, input logic [LIMIT_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_limit(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(input logic [LIMIT_W-1:0] prob_lim,
                              input logic [LIMIT_W-1:0] prot_lim);
        settle();
        write_limit(REG_PROBATION_LIMIT, prob_lim);
        write_limit(REG_PROTECTED_LIMIT, prot_lim);
    endtask

    task automatic run_random(input int count);
        int               r;
        logic             op;
        logic [KEY_W-1:0] k;
        key_pool = new[$urandom_range(4, 18)];
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        if ($urandom_range(0, 1))
        begin
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7FFF_FFFF;
        end
        for (int n = 0; n < count; n++)
        begin
            r  = $urandom_range(0, 99);
            op = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
            if (r < 85)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                k = $urandom;
            send_item(op, k, $urandom);
        end
        end_stream();
    endtask

    initial
    begin : main
        logic [LIMIT_W-1:0] prob_set[8];
        logic [LIMIT_W-1:0] prot_set[8];
        sb           = new();
        steady       = 1'b0;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        opcode       = OP_GET;
        key          = '0;
        write_value  = '0;
        out_ready    = 1'b0;
        prob_set = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd3, 4'd8, 4'd2, 4'd5};
        prot_set = '{4'd15, 4'd0, 4'd8, 4'd8, 4'd2, 4'd0, 4'd15, 4'd4};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_GET, 32'h5555_5555, 32'hAAAA_AAAA);
        end_stream();

        // Probation limit lowered below its fill, with protected unable to keep anything.
        set_limits(4'd1, 4'd0);
        send_item(OP_PUT, 32'h0BAD_F00D, 32'hAAAA_AAAA);
        send_item(OP_GET, 32'h8000_0000, 32'h5555_5555);
        send_item(OP_PUT, 32'h5555_5555, 32'h5555_5555);
        send_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_GET, 32'h5555_5555, 32'h0000_0000);
        end_stream();

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph < 8)
                set_limits(prob_set[ph], prot_set[ph]);
            else
                set_limits(LIMIT_W'($urandom_range(0, 15)), LIMIT_W'($urandom_range(0, 15)));
            steady = (ph == 2 || ph == 6);
            if (ph == 1)
                hold_request = 1'b1;
            run_random(ITEMS_PER_RUN);
        end
        steady = 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
